FILE: hw/rtl/tfr_pkg.sv
package tfr_pkg;

	// default payload buffer size in bytes
	localparam int PAYLOAD_MAX_DEF = 32;

	// longest text message that is replayed character by character
	localparam int TEXT_MAX = 32;

	// depth of the queue between parser and decoder
	localparam int QUEUE_DEPTH = 4;

	// leading payload bytes kept aside for the fixed-layout frames
	localparam int GATHER_N  = 9;
	localparam int GATHER_IW = $clog2(GATHER_N);

	// sync byte after reset
	localparam logic [7:0] SYNC_RESET = 8'hAA;

	// command codes
	localparam logic [7:0] CMD_DRIVE  = 8'h01;
	localparam logic [7:0] CMD_ENERGY = 8'h02;
	localparam logic [7:0] CMD_POWER  = 8'h03;
	localparam logic [7:0] CMD_STATUS = 8'h04;
	localparam logic [7:0] CMD_TEXT   = 8'h05;

	// exact payload lengths of the fixed-layout frames
	localparam int LEN_FAST      = 6;
	localparam int LEN_AWARENESS = 9;
	localparam int LEN_GRAPH     = 8;
	localparam int LEN_HEARTBEAT = 1;

	// result kinds
	typedef enum logic [2:0] {
		KIND_FAST      = 3'd0,
		KIND_AWARENESS = 3'd1,
		KIND_GRAPH     = 3'd2,
		KIND_HEARTBEAT = 3'd3,
		KIND_TEXT      = 3'd4,
		KIND_IGNORED   = 3'd5
	} kind_t;

	// held telemetry record
	typedef struct packed {
		logic [7:0]  message_code;
		logic [31:0] current_bits;
		logic [31:0] battery_bits;
		logic [31:0] efficiency_bits;
		logic [31:0] consumption_bits;
		logic [7:0]  lap_count;
		logic [31:0] speed_bits;
		logic [15:0] rpm;
	} record_t;

endpackage

FILE: hw/rtl/telemetry_frame_receiver_top.sv
// Telemetry frame receiver.
// Received bytes enter on the s_axis channel, one byte per transfer. A frame is
// a sync byte (cfg_wr_data sets its value, 0xAA after reset), a command byte, a
// length byte and the payload. Decoded results leave on the m_axis channel: the
// whole held telemetry record in tdata, the result kind in tuser and tlast on
// the final result of a frame. A text frame gives one result per character.
// Throughput: the parser takes one byte per cycle while the four-entry queue to
// the decoder has room; the decoder drains one payload byte per cycle, so the
// sustained rate is one byte per cycle outside of frame completion.
// Result path: the last payload byte of a fixed-layout or ignored frame passes
// through the queue and the decode state into the result register. A text frame
// reads each character from the payload store read port before it is output.
// While a result waits on m_axis_tready the decoder holds and the queue fills;
// s_axis_tready drops only once the queue is full.
// Reset clears the parser to waiting for sync, empties the queue and the result
// register, and zeroes the held record; the payload store needs no clearing.
module telemetry_frame_receiver_top #(
	parameter int PAYLOAD_MAX = tfr_pkg::PAYLOAD_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// rpm, speed_bits, lap_count, consumption_bits, efficiency_bits,
	// battery_bits, current_bits, message_code, text_byte
	output logic [199:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // frame_kind
	output logic         m_axis_tlast    // last
);

	localparam int IDX_W = $clog2(PAYLOAD_MAX);
	localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);
	localparam int OP_W  = 1 + 8 + LEN_W + IDX_W + 8;

	logic             push;
	logic [OP_W-1:0]  push_data;
	logic             q_not_full;
	logic             pop;
	logic [OP_W-1:0]  pop_data;
	logic             q_not_empty;
	tfr_pkg::record_t rec;
	logic [7:0]       text;

	// parser
	tfr_front #(
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.IDX_W       (IDX_W),
		.LEN_W       (LEN_W),
		.OP_W        (OP_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.op_push     (push),
		.op_data     (push_data),
		.op_not_full (q_not_full)
	);

	// payload queue
	tfr_queue #(
		.WIDTH (OP_W),
		.DEPTH (tfr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.not_full  (q_not_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	// decoder and result stage
	tfr_back #(
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.IDX_W       (IDX_W),
		.LEN_W       (LEN_W),
		.OP_W        (OP_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_not_empty),
		.op_data   (pop_data),
		.op_pop    (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_rec   (rec),
		.out_text  (text),
		.out_last  (m_axis_tlast)
	);

	// result packing, highest field first
	assign m_axis_tdata = {text, rec.message_code, rec.current_bits, rec.battery_bits,
	                       rec.efficiency_bits, rec.consumption_bits, rec.lap_count,
	                       rec.speed_bits, rec.rpm};

endmodule

FILE: hw/rtl/tfr_queue.sv
module tfr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tfr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/tfr_front.sv
module tfr_front #(
	parameter int PAYLOAD_MAX = tfr_pkg::PAYLOAD_MAX_DEF,
	parameter int IDX_W = $clog2(PAYLOAD_MAX),
	parameter int LEN_W = $clog2(PAYLOAD_MAX + 1),
	parameter int OP_W  = 1 + 8 + LEN_W + IDX_W + 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	output logic            op_push,
	output logic [OP_W-1:0] op_data,
	input  logic            op_not_full
);

	typedef enum logic [3:0] {
		PH_SYNC = 4'b0001,
		PH_CMD  = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_PAY  = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [7:0]       sync_q;
	logic [7:0]       cmd_q, cmd_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] fill_q, fill_d;
	logic [LEN_W-1:0] fill_nx;
	logic             accept;
	logic             frame_end;

	assign in_ready = op_not_full;
	assign accept   = in_valid && in_ready;
	assign fill_nx  = fill_q + 1'b1;

	// parser state machine
	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		fill_d    = fill_q;
		op_push   = 1'b0;
		frame_end = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (in_byte == sync_q) begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = in_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					fill_d = '0;
					if (in_byte > 8'(PAYLOAD_MAX)) begin
						phase_d = PH_SYNC;
					end else begin
						len_d   = LEN_W'(in_byte);
						phase_d = PH_PAY;
					end
				end
				PH_PAY: begin
					op_push = 1'b1;
					fill_d  = fill_nx;
					if (fill_nx >= len_q) begin
						frame_end = 1'b1;
						phase_d   = PH_SYNC;
					end
				end
				default: phase_d = PH_SYNC;
			endcase
		end
	end

	// payload byte transfer towards the decoder
	assign op_data = {frame_end, cmd_q, len_q, fill_q[IDX_W-1:0], in_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			sync_q  <= tfr_pkg::SYNC_RESET;
			cmd_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			if (cfg_wr_en) begin
				sync_q <= cfg_wr_data;
			end
		end
	end

endmodule

FILE: hw/rtl/tfr_back.sv
module tfr_back #(
	parameter int PAYLOAD_MAX = tfr_pkg::PAYLOAD_MAX_DEF,
	parameter int IDX_W = $clog2(PAYLOAD_MAX),
	parameter int LEN_W = $clog2(PAYLOAD_MAX + 1),
	parameter int OP_W  = 1 + 8 + LEN_W + IDX_W + 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  logic [OP_W-1:0]  op_data,
	output logic             op_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       out_kind,
	output tfr_pkg::record_t out_rec,
	output logic [7:0]       out_text,
	output logic             out_last
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_DECODE  = 4'b0010,
		ST_TXT_RD  = 4'b0100,
		ST_TXT_OUT = 4'b1000
	} state_t;

	state_t             st_q, st_d;
	logic [7:0]         mem_q [PAYLOAD_MAX];
	logic [7:0]         gath_q [tfr_pkg::GATHER_N];
	logic [7:0]         rdata_q;
	logic [7:0]         cmd_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   ridx_q, ridx_d;
	tfr_pkg::record_t   held_q, held_d;

	logic               op_end;
	logic [7:0]         op_cmd;
	logic [LEN_W-1:0]   op_len;
	logic [IDX_W-1:0]   op_idx;
	logic [7:0]         op_byte;

	logic               rd_en;
	logic               ld;
	tfr_pkg::kind_t     ld_kind;
	logic [7:0]         ld_text;
	logic               ld_last;
	logic               out_free;
	logic               is_text;
	logic               txt_last;

	tfr_pkg::kind_t     out_kind_q;
	tfr_pkg::record_t   out_rec_q;
	logic [7:0]         out_text_q;
	logic               out_last_q;
	logic               out_valid_q;

	assign {op_end, op_cmd, op_len, op_idx, op_byte} = op_data;

	assign out_free = !out_valid_q || out_ready;
	assign is_text  = (cmd_q == tfr_pkg::CMD_TEXT) && (len_q != '0)
	                  && (int'(len_q) <= tfr_pkg::TEXT_MAX);
	assign txt_last = ((LEN_W'(ridx_q) + 1'b1) == len_q);
	assign op_pop   = (st_q == ST_IDLE) && op_valid;

	// payload store and its registered read port
	always_ff @(posedge clk) begin
		if (op_pop) begin
			mem_q[op_idx] <= op_byte;
		end
		if (rd_en) begin
			rdata_q <= mem_q[ridx_q];
		end
	end

	// copy of the leading bytes for the fixed-layout frames
	always_ff @(posedge clk) begin
		if (op_pop && (int'(op_idx) < tfr_pkg::GATHER_N)) begin
			gath_q[op_idx[tfr_pkg::GATHER_IW-1:0]] <= op_byte;
		end
	end

	// frame header of the frame under decode
	always_ff @(posedge clk) begin
		if (op_pop && op_end) begin
			cmd_q <= op_cmd;
			len_q <= op_len;
		end
	end

	// decode and replay sequencer
	always_comb begin
		st_d    = st_q;
		ridx_d  = ridx_q;
		held_d  = held_q;
		rd_en   = 1'b0;
		ld      = 1'b0;
		ld_kind = tfr_pkg::KIND_IGNORED;
		ld_text = '0;
		ld_last = 1'b1;
		unique case (st_q)
			ST_IDLE: begin
				if (op_valid && op_end) begin
					st_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (is_text) begin
					ridx_d = '0;
					st_d   = ST_TXT_RD;
				end else if (out_free) begin
					ld   = 1'b1;
					st_d = ST_IDLE;
					unique case (cmd_q)
						tfr_pkg::CMD_DRIVE: begin
							if (len_q == LEN_W'(tfr_pkg::LEN_FAST)) begin
								ld_kind           = tfr_pkg::KIND_FAST;
								held_d.rpm        = {gath_q[0], gath_q[1]};
								held_d.speed_bits = {gath_q[5], gath_q[4], gath_q[3], gath_q[2]};
							end
						end
						tfr_pkg::CMD_ENERGY: begin
							if (len_q == LEN_W'(tfr_pkg::LEN_AWARENESS)) begin
								ld_kind                 = tfr_pkg::KIND_AWARENESS;
								held_d.lap_count        = gath_q[0];
								held_d.consumption_bits =
									{gath_q[4], gath_q[3], gath_q[2], gath_q[1]};
								held_d.efficiency_bits  =
									{gath_q[8], gath_q[7], gath_q[6], gath_q[5]};
							end
						end
						tfr_pkg::CMD_POWER: begin
							if (len_q == LEN_W'(tfr_pkg::LEN_GRAPH)) begin
								ld_kind             = tfr_pkg::KIND_GRAPH;
								held_d.battery_bits =
									{gath_q[3], gath_q[2], gath_q[1], gath_q[0]};
								held_d.current_bits =
									{gath_q[7], gath_q[6], gath_q[5], gath_q[4]};
							end
						end
						tfr_pkg::CMD_STATUS: begin
							if (len_q == LEN_W'(tfr_pkg::LEN_HEARTBEAT)) begin
								ld_kind             = tfr_pkg::KIND_HEARTBEAT;
								held_d.message_code = gath_q[0];
							end
						end
						default: ld_kind = tfr_pkg::KIND_IGNORED;
					endcase
				end
			end
			ST_TXT_RD: begin
				rd_en = 1'b1;
				st_d  = ST_TXT_OUT;
			end
			ST_TXT_OUT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = tfr_pkg::KIND_TEXT;
					ld_text = rdata_q;
					ld_last = txt_last;
					if (txt_last) begin
						st_d = ST_IDLE;
					end else begin
						ridx_d = ridx_q + 1'b1;
						st_d   = ST_TXT_RD;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ridx_q <= '0;
			held_q <= '0;
		end else begin
			st_q   <= st_d;
			ridx_q <= ridx_d;
			held_q <= held_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_kind_q <= ld_kind;
			out_rec_q  <= held_d;
			out_text_q <= ld_text;
			out_last_q <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_rec   = out_rec_q;
	assign out_text  = out_text_q;
	assign out_last  = out_last_q;

endmodule

FILE: sim/frame_result_checker.sv
module frame_result_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [199:0] m_axis_tdata,
	input  logic [2:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		HUNT_SYNC,
		TAKE_CMD,
		TAKE_LEN,
		TAKE_PAYLOAD
	} parse_state_t;

	typedef struct {
		tfr_pkg::kind_t   kind;
		tfr_pkg::record_t rec;
		logic [7:0]       text;
		logic             last;
	} frame_result_t;

	// mirrored parser state and held telemetry
	parse_state_t     parse_state;
	logic [7:0]       sync_copy;
	logic [7:0]       cur_cmd;
	logic [7:0]       cur_len;
	int               fill;
	logic [7:0]       pay_buf [tfr_pkg::PAYLOAD_MAX_DEF];
	tfr_pkg::record_t held;
	frame_result_t    result_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// four payload bytes, least significant first
	function automatic logic [31:0] le_word(input int at);
		return {pay_buf[at + 3], pay_buf[at + 2], pay_buf[at + 1], pay_buf[at]};
	endfunction

	function automatic frame_result_t make_result(input tfr_pkg::kind_t kind,
			input logic [7:0] text, input logic last);
		frame_result_t r;
		r.kind = kind;
		r.rec = held;
		r.text = text;
		r.last = last;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_result_t    want;
		tfr_pkg::record_t got_rec;
		tfr_pkg::kind_t   kind;
		logic [7:0]       b;
		if (!arst_n) begin
			parse_state = HUNT_SYNC;
			sync_copy = tfr_pkg::SYNC_RESET;
			cur_cmd = '0;
			cur_len = '0;
			fill = 0;
			held = '0;
			result_q.delete();
		end else begin
			// compare each result transfer with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					$error("result transfer with nothing expected, kind %0d", m_axis_tuser);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					got_rec = m_axis_tdata[191:0];
					check_field("frame_kind", want.kind, m_axis_tuser);
					check_field("rpm", want.rec.rpm, got_rec.rpm);
					check_field("speed_bits", want.rec.speed_bits, got_rec.speed_bits);
					check_field("lap_count", want.rec.lap_count, got_rec.lap_count);
					check_field("consumption_bits", want.rec.consumption_bits,
						got_rec.consumption_bits);
					check_field("efficiency_bits", want.rec.efficiency_bits,
						got_rec.efficiency_bits);
					check_field("battery_bits", want.rec.battery_bits, got_rec.battery_bits);
					check_field("current_bits", want.rec.current_bits, got_rec.current_bits);
					check_field("message_code", want.rec.message_code, got_rec.message_code);
					check_field("text_byte", want.text, m_axis_tdata[199:192]);
					check_field("last", want.last, m_axis_tlast);
				end
			end

			// parse each byte transfer and predict what it causes
			if (s_axis_tvalid && s_axis_tready) begin
				b = s_axis_tdata;
				case (parse_state)
					HUNT_SYNC: begin
						if (b == sync_copy)
							parse_state = TAKE_CMD;
					end
					TAKE_CMD: begin
						cur_cmd = b;
						parse_state = TAKE_LEN;
					end
					TAKE_LEN: begin
						fill = 0;
						if (b > tfr_pkg::PAYLOAD_MAX_DEF) begin
							parse_state = HUNT_SYNC;
						end else begin
							cur_len = b;
							parse_state = TAKE_PAYLOAD;
						end
					end
					default: begin
						if (fill < tfr_pkg::PAYLOAD_MAX_DEF)
							pay_buf[fill] = b;
						fill++;
						if (fill >= cur_len) begin
							parse_state = HUNT_SYNC;
							// decode by command and exact length
							kind = tfr_pkg::KIND_IGNORED;
							case (cur_cmd)
								tfr_pkg::CMD_DRIVE: begin
									if (cur_len == tfr_pkg::LEN_FAST) begin
										held.rpm = {pay_buf[0], pay_buf[1]};
										held.speed_bits = le_word(2);
										kind = tfr_pkg::KIND_FAST;
									end
								end
								tfr_pkg::CMD_ENERGY: begin
									if (cur_len == tfr_pkg::LEN_AWARENESS) begin
										held.lap_count = pay_buf[0];
										held.consumption_bits = le_word(1);
										held.efficiency_bits = le_word(5);
										kind = tfr_pkg::KIND_AWARENESS;
									end
								end
								tfr_pkg::CMD_POWER: begin
									if (cur_len == tfr_pkg::LEN_GRAPH) begin
										held.battery_bits = le_word(0);
										held.current_bits = le_word(4);
										kind = tfr_pkg::KIND_GRAPH;
									end
								end
								tfr_pkg::CMD_STATUS: begin
									if (cur_len == tfr_pkg::LEN_HEARTBEAT) begin
										held.message_code = pay_buf[0];
										kind = tfr_pkg::KIND_HEARTBEAT;
									end
								end
								tfr_pkg::CMD_TEXT: begin
									if (cur_len > 0 && cur_len <= tfr_pkg::TEXT_MAX &&
											cur_len <= tfr_pkg::PAYLOAD_MAX_DEF)
										kind = tfr_pkg::KIND_TEXT;
								end
								default: ;
							endcase
							// text replays one result per character
							if (kind == tfr_pkg::KIND_TEXT) begin
								for (int i = 0; i < cur_len; i++)
									result_q.push_back(make_result(kind, pay_buf[i],
										i + 1 == cur_len));
							end else begin
								result_q.push_back(make_result(kind, 8'h00, 1'b1));
							end
						end
					end
				endcase
			end

			// sync byte register, effective from the next transfer on
			if (cfg_wr_en)
				sync_copy = cfg_wr_data;
		end
		pending = result_q.size();
	end

endmodule

FILE: sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASE_BYTES    = 80;
	localparam logic [7:0] CMD_UNKNOWN_LO = 8'h00;
	localparam logic [7:0] CMD_UNKNOWN_HI = 8'hFF;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_SYNC
	} fill_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [7:0]   cfg_wr_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [199:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;

	int         fail_count;
	int         pending;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         bytes_sent = 0;
	int         quiet_cycles = 0;
	logic [7:0] frame_sync = tfr_pkg::SYNC_RESET;

	telemetry_frame_receiver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	frame_result_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one byte transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_noise();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == frame_sync);
		send_byte(b);
	endtask

	// sync, command, length and payload; zero length still takes one byte
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input fill_t pat);
		int n;
		n = (len > tfr_pkg::PAYLOAD_MAX_DEF) ? 0 : ((len == 0) ? 1 : int'(len));
		send_byte(frame_sync);
		send_byte(cmd);
		send_byte(len);
		for (int i = 0; i < n; i++) begin
			case (pat)
				FILL_ZERO: send_byte(8'h00);
				FILL_ONES: send_byte(8'hFF);
				FILL_SYNC: send_byte(frame_sync);
				default:   send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// mostly well-formed frames, with noise and broken frames mixed in
	task automatic send_random();
		int r;
		int len;
		logic [7:0] cmd;
		r = $urandom_range(0, 99);
		if (r < 14) begin
			send_frame(tfr_pkg::CMD_DRIVE, 8'(tfr_pkg::LEN_FAST), FILL_RANDOM);
		end else if (r < 28) begin
			send_frame(tfr_pkg::CMD_ENERGY, 8'(tfr_pkg::LEN_AWARENESS), FILL_RANDOM);
		end else if (r < 42) begin
			send_frame(tfr_pkg::CMD_POWER, 8'(tfr_pkg::LEN_GRAPH), FILL_RANDOM);
		end else if (r < 56) begin
			send_frame(tfr_pkg::CMD_STATUS, 8'(tfr_pkg::LEN_HEARTBEAT), FILL_RANDOM);
		end else if (r < 72) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, tfr_pkg::TEXT_MAX)
			                                  : $urandom_range(1, 8);
			send_frame(tfr_pkg::CMD_TEXT, 8'(len), FILL_RANDOM);
		end else if (r < 80) begin
			cmd = 8'($urandom_range(tfr_pkg::CMD_DRIVE, tfr_pkg::CMD_TEXT));
			send_frame(cmd, 8'($urandom_range(0, tfr_pkg::PAYLOAD_MAX_DEF)), FILL_RANDOM);
		end else if (r < 85) begin
			cmd = 8'($urandom_range(0, 255));
			if (cmd >= tfr_pkg::CMD_DRIVE && cmd <= tfr_pkg::CMD_TEXT)
				cmd = CMD_UNKNOWN_HI;
			send_frame(cmd, 8'($urandom_range(0, tfr_pkg::PAYLOAD_MAX_DEF)), FILL_RANDOM);
		end else if (r < 90) begin
			send_frame(8'($urandom_range(0, 255)),
				8'($urandom_range(tfr_pkg::PAYLOAD_MAX_DEF + 1, 255)), FILL_RANDOM);
		end else if (r < 96) begin
			repeat ($urandom_range(1, 3))
				send_noise();
		end else begin
			// cut-off frame: later bytes fill the rest of its payload
			len = $urandom_range(1, tfr_pkg::PAYLOAD_MAX_DEF);
			send_byte(frame_sync);
			send_byte(8'($urandom_range(tfr_pkg::CMD_DRIVE, tfr_pkg::CMD_TEXT)));
			send_byte(8'(len));
			repeat ($urandom_range(0, len - 1))
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// wait for every predicted result, then let the block go quiet
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int phase_end;
		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int p = 0; p < 4; p++) begin
			// new sync value and idle pattern per phase
			if (p > 0) begin
				settle();
				case (p)
					1:       frame_sync = 8'h00;
					2:       frame_sync = 8'hFF;
					default: frame_sync = 8'($urandom_range(1, 254));
				endcase
				cfg_wr_en = 1'b1;
				cfg_wr_data = frame_sync;
				@(negedge clk);
				cfg_wr_en = 1'b0;
			end
			idle_pct  = (p == 1) ? 49 : ((p == 3) ? 22 : 0);
			stall_pct = (p == 2) ? 49 : ((p == 3) ? 22 : 0);

			// directed frames covering every command and the corner cases
			if (p == 0) begin
				send_noise();
				send_noise();
				send_frame(tfr_pkg::CMD_DRIVE, 8'(tfr_pkg::LEN_FAST), FILL_ONES);
				send_frame(tfr_pkg::CMD_DRIVE, 8'(tfr_pkg::LEN_FAST), FILL_ZERO);
				send_frame(tfr_pkg::CMD_ENERGY, 8'(tfr_pkg::LEN_AWARENESS), FILL_RANDOM);
				send_frame(tfr_pkg::CMD_POWER, 8'(tfr_pkg::LEN_GRAPH), FILL_ONES);
				send_frame(tfr_pkg::CMD_STATUS, 8'(tfr_pkg::LEN_HEARTBEAT), FILL_RANDOM);
				send_frame(tfr_pkg::CMD_TEXT, 8'd1, FILL_RANDOM);
				send_frame(tfr_pkg::CMD_TEXT, 8'(tfr_pkg::TEXT_MAX), FILL_SYNC);
				send_frame(tfr_pkg::CMD_DRIVE, 8'(tfr_pkg::LEN_FAST - 1), FILL_RANDOM);
				send_frame(tfr_pkg::CMD_POWER, 8'(tfr_pkg::PAYLOAD_MAX_DEF), FILL_RANDOM);
				send_frame(CMD_UNKNOWN_LO, 8'd3, FILL_RANDOM);
				send_frame(CMD_UNKNOWN_HI, 8'd2, FILL_ONES);
				send_frame(tfr_pkg::CMD_STATUS, 8'd0, FILL_RANDOM);
				send_frame(tfr_pkg::CMD_TEXT, 8'd0, FILL_RANDOM);
				send_frame(tfr_pkg::CMD_DRIVE, 8'(tfr_pkg::PAYLOAD_MAX_DEF + 1), FILL_RANDOM);
				send_frame(tfr_pkg::CMD_TEXT, 8'hFF, FILL_RANDOM);
				send_frame(tfr_pkg::CMD_STATUS, 8'(tfr_pkg::LEN_HEARTBEAT), FILL_ONES);
			end

			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end)
				send_random();
		end

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
